/* design/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// shared constants and types of the numeric text classifier
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned ClassW = 2;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned DigitW = 4;
  localparam int unsigned WideW  = ValueW + DigitW;

  // scan phases
  localparam logic [PhaseW-1:0] PH_LEAD  = 3'd0;
  localparam logic [PhaseW-1:0] PH_INT   = 3'd1;
  localparam logic [PhaseW-1:0] PH_FRAC  = 3'd2;
  localparam logic [PhaseW-1:0] PH_EXP0  = 3'd3;
  localparam logic [PhaseW-1:0] PH_EXPS  = 3'd4;
  localparam logic [PhaseW-1:0] PH_EXPD  = 3'd5;
  localparam logic [PhaseW-1:0] PH_TRAIL = 3'd6;
  localparam logic [PhaseW-1:0] PH_ERR   = 3'd7;

  // result classes
  localparam logic [ClassW-1:0] CLS_NAN  = 2'd0;
  localparam logic [ClassW-1:0] CLS_INT  = 2'd1;
  localparam logic [ClassW-1:0] CLS_REAL = 2'd2;

  // characters
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_UP_E  = 8'h45;
  localparam logic [CharW-1:0] CH_LO_E  = 8'h65;

  localparam logic [ValueW-1:0] LimitMag = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic [ValueW-1:0] MaxPos   = {1'b0, {(ValueW-1){1'b1}}};

  // scan state after one character, handed to the result stage
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              seen_digit;
    logic              seen_dot_or_exp;
    logic              is_negative;
    logic [ValueW-1:0] magnitude;
    logic              overflowed;
  } scan_t;

endpackage

/* design/ntc_if.sv */
// ----------------------------------------------------------------------------
// ntc_char_if / ntc_class_if
// valid/ready channels for input characters and classification results
// ----------------------------------------------------------------------------
interface ntc_char_if;
  logic                        valid;
  logic                        ready;
  logic [ntc_pkg::CharW-1:0]   char_code;
  logic                        final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface ntc_class_if;
  logic                             valid;
  logic                             ready;
  logic [ntc_pkg::ClassW-1:0]       number_class;
  logic signed [ntc_pkg::ValueW-1:0] int_value;
  logic                             saturated;

  modport source (output valid, output number_class, output int_value,
                  output saturated, input ready);
  modport sink   (input valid, input number_class, input int_value,
                  input saturated, output ready);
endinterface

/* design/ntc_lexer.sv */
// ----------------------------------------------------------------------------
// ntc_lexer
// scan state registers, phase transitions and decimal accumulation
// ----------------------------------------------------------------------------
module ntc_lexer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [ntc_pkg::CharW-1:0] char_code_i,
  input  logic                      final_char_i,
  output ntc_pkg::scan_t            scan_o
);

  logic [ntc_pkg::PhaseW-1:0] phase_q;
  logic                       seen_digit_q;
  logic                       seen_dot_or_exp_q;
  logic                       is_negative_q;
  logic [ntc_pkg::ValueW-1:0] magnitude_q;
  logic                       overflowed_q;

  logic                       is_dig;
  logic                       is_sgn;
  logic                       is_exp;
  logic                       is_spc;
  logic [ntc_pkg::DigitW-1:0] digit;
  logic [ntc_pkg::WideW-1:0]  acc_sum;
  logic                       acc_over;
  logic                       do_add;
  ntc_pkg::scan_t             nxt;

  assign is_dig = (char_code_i >= ntc_pkg::CH_ZERO) && (char_code_i <= ntc_pkg::CH_NINE);
  assign is_sgn = (char_code_i == ntc_pkg::CH_PLUS) || (char_code_i == ntc_pkg::CH_MINUS);
  assign is_exp = (char_code_i == ntc_pkg::CH_LO_E) || (char_code_i == ntc_pkg::CH_UP_E);
  assign is_spc = (char_code_i == ntc_pkg::CH_SPACE);
  assign digit  = ntc_pkg::DigitW'(char_code_i - ntc_pkg::CH_ZERO);

  // magnitude * 10 + digit as two shifted terms
  assign acc_sum  = {1'b0, magnitude_q, 3'b000} + {3'b000, magnitude_q, 1'b0}
                  + {{ntc_pkg::ValueW{1'b0}}, digit};
  assign acc_over = acc_sum > {{ntc_pkg::DigitW{1'b0}}, ntc_pkg::LimitMag};

  always_comb begin
    nxt.phase           = ntc_pkg::PH_ERR;
    nxt.seen_digit      = seen_digit_q;
    nxt.seen_dot_or_exp = seen_dot_or_exp_q;
    nxt.is_negative     = is_negative_q;
    do_add              = 1'b0;
    unique case (phase_q)
      ntc_pkg::PH_LEAD: begin
        if (is_spc) begin
          nxt.phase = ntc_pkg::PH_LEAD;
        end else if (is_sgn) begin
          nxt.is_negative = (char_code_i == ntc_pkg::CH_MINUS);
          nxt.phase       = ntc_pkg::PH_INT;
        end else if (is_dig) begin
          nxt.seen_digit = 1'b1;
          do_add         = 1'b1;
          nxt.phase      = ntc_pkg::PH_INT;
        end else if (char_code_i == ntc_pkg::CH_DOT) begin
          nxt.seen_dot_or_exp = 1'b1;
          nxt.phase           = ntc_pkg::PH_FRAC;
        end
      end
      ntc_pkg::PH_INT: begin
        if (is_dig) begin
          nxt.seen_digit = 1'b1;
          do_add         = 1'b1;
          nxt.phase      = ntc_pkg::PH_INT;
        end else if (char_code_i == ntc_pkg::CH_DOT) begin
          nxt.seen_dot_or_exp = 1'b1;
          nxt.phase           = ntc_pkg::PH_FRAC;
        end else if (is_exp) begin
          nxt.seen_dot_or_exp = 1'b1;
          nxt.phase = seen_digit_q ? ntc_pkg::PH_EXP0 : ntc_pkg::PH_ERR;
        end else if (is_spc) begin
          nxt.phase = seen_digit_q ? ntc_pkg::PH_TRAIL : ntc_pkg::PH_ERR;
        end
      end
      ntc_pkg::PH_FRAC: begin
        if (is_dig) begin
          nxt.seen_digit = 1'b1;
          nxt.phase      = ntc_pkg::PH_FRAC;
        end else if (is_exp) begin
          nxt.phase = seen_digit_q ? ntc_pkg::PH_EXP0 : ntc_pkg::PH_ERR;
        end else if (is_spc) begin
          nxt.phase = seen_digit_q ? ntc_pkg::PH_TRAIL : ntc_pkg::PH_ERR;
        end
      end
      ntc_pkg::PH_EXP0: begin
        if (is_sgn) begin
          nxt.phase = ntc_pkg::PH_EXPS;
        end else if (is_dig) begin
          nxt.phase = ntc_pkg::PH_EXPD;
        end
      end
      ntc_pkg::PH_EXPS: begin
        if (is_dig) begin
          nxt.phase = ntc_pkg::PH_EXPD;
        end
      end
      ntc_pkg::PH_EXPD: begin
        if (is_dig) begin
          nxt.phase = ntc_pkg::PH_EXPD;
        end else if (is_spc) begin
          nxt.phase = ntc_pkg::PH_TRAIL;
        end
      end
      ntc_pkg::PH_TRAIL: begin
        if (is_spc) begin
          nxt.phase = ntc_pkg::PH_TRAIL;
        end
      end
      default: begin
        nxt.phase = ntc_pkg::PH_ERR;
      end
    endcase

    nxt.magnitude  = magnitude_q;
    nxt.overflowed = overflowed_q;
    if (do_add && !overflowed_q) begin
      if (acc_over) begin
        nxt.overflowed = 1'b1;
        nxt.magnitude  = ntc_pkg::LimitMag;
      end else begin
        nxt.magnitude = acc_sum[ntc_pkg::ValueW-1:0];
      end
    end
  end

  assign scan_o = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= ntc_pkg::PH_LEAD;
      seen_digit_q      <= 1'b0;
      seen_dot_or_exp_q <= 1'b0;
      is_negative_q     <= 1'b0;
      magnitude_q       <= '0;
      overflowed_q      <= 1'b0;
    end else if (step_i) begin
      if (final_char_i) begin
        phase_q           <= ntc_pkg::PH_LEAD;
        seen_digit_q      <= 1'b0;
        seen_dot_or_exp_q <= 1'b0;
        is_negative_q     <= 1'b0;
        magnitude_q       <= '0;
        overflowed_q      <= 1'b0;
      end else begin
        phase_q           <= nxt.phase;
        seen_digit_q      <= nxt.seen_digit;
        seen_dot_or_exp_q <= nxt.seen_dot_or_exp;
        is_negative_q     <= nxt.is_negative;
        magnitude_q       <= nxt.magnitude;
        overflowed_q      <= nxt.overflowed;
      end
    end
  end

endmodule

/* design/ntc_result.sv */
// ----------------------------------------------------------------------------
// ntc_result
// class and saturated value from the final scan state, output register
// ----------------------------------------------------------------------------
module ntc_result (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ntc_pkg::scan_t scan_i,
  ntc_class_if.source    class_o
);

  logic                       valid_q;
  logic [ntc_pkg::ClassW-1:0] class_q;
  logic [ntc_pkg::ClassW-1:0] class_d;
  logic [ntc_pkg::ValueW-1:0] value_q;
  logic [ntc_pkg::ValueW-1:0] value_d;
  logic                       sat_q;
  logic                       sat_d;

  always_comb begin
    unique case (scan_i.phase)
      ntc_pkg::PH_INT:   class_d = scan_i.seen_digit ? ntc_pkg::CLS_INT : ntc_pkg::CLS_NAN;
      ntc_pkg::PH_FRAC:  class_d = scan_i.seen_digit ? ntc_pkg::CLS_REAL : ntc_pkg::CLS_NAN;
      ntc_pkg::PH_EXPD:  class_d = ntc_pkg::CLS_REAL;
      ntc_pkg::PH_TRAIL: class_d = scan_i.seen_dot_or_exp ? ntc_pkg::CLS_REAL
                                                          : ntc_pkg::CLS_INT;
      default:           class_d = ntc_pkg::CLS_NAN;
    endcase

    value_d = '0;
    sat_d   = 1'b0;
    if (class_d == ntc_pkg::CLS_INT) begin
      if (scan_i.is_negative) begin
        sat_d   = scan_i.overflowed;
        value_d = scan_i.overflowed ? ntc_pkg::LimitMag : (-scan_i.magnitude);
      end else if (scan_i.overflowed || scan_i.magnitude[ntc_pkg::ValueW-1]) begin
        sat_d   = 1'b1;
        value_d = ntc_pkg::MaxPos;
      end else begin
        value_d = scan_i.magnitude;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (class_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      class_q <= class_d;
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign class_o.valid        = valid_q;
  assign class_o.number_class = class_q;
  assign class_o.int_value    = $signed(value_q);
  assign class_o.saturated    = sat_q;

endmodule

/* design/numeric_text_classifier_top.sv */
// ----------------------------------------------------------------------------
// numeric_text_classifier_top
// classifies decimal text, one character per item, as not a number, integer
// or real, with the saturated integer value
// ----------------------------------------------------------------------------
// result: a final character is taken into the input register and loads the result register when that is free
// throughput: one character per cycle, set by the single scan state update, while no final character waits
// a stalled result holds the next final character in the input stage, and the characters behind it wait too
// reset: asynchronous, clears the scan state, the input stage and result valid
module numeric_text_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntc_char_if.sink    char_i,
  ntc_class_if.source class_o
);

  logic                      in_valid_q;
  logic [ntc_pkg::CharW-1:0] in_char_q;
  logic                      in_final_q;
  logic                      step;
  logic                      out_free;
  ntc_pkg::scan_t            scan;

  assign out_free     = !class_o.valid || class_o.ready;
  assign step         = in_valid_q && (!in_final_q || out_free);
  assign char_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      in_char_q  <= char_i.char_code;
      in_final_q <= char_i.final_char;
    end
  end

  ntc_lexer u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .char_code_i  (in_char_q),
    .final_char_i (in_final_q),
    .scan_o       (scan)
  );

  ntc_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && in_final_q),
    .scan_i  (scan),
    .class_o (class_o)
  );

endmodule

/* design/ntc_checker.sv */
// ----------------------------------------------------------------------------
// ntc_checker
// port-level checks of the classifier result channel
// ----------------------------------------------------------------------------
module ntc_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_ready_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [ntc_pkg::ClassW-1:0]        number_class_i,
  input  logic signed [ntc_pkg::ValueW-1:0] int_value_i,
  input  logic                              saturated_i
);

  logic out_wait;
  assign out_wait = out_valid_i && !out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wait |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wait |=> $stable(number_class_i) && $stable(int_value_i)
                 && $stable(saturated_i))
    else $error("result changed while stalled");

  a_non_int_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (number_class_i != ntc_pkg::CLS_INT)
      |-> (int_value_i == '0) && !saturated_i)
    else $error("non-integer result carries a value");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i
      |-> ($unsigned(int_value_i) == ntc_pkg::LimitMag)
       || ($unsigned(int_value_i) == ntc_pkg::MaxPos))
    else $error("saturated value not at a limit");

  a_in_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind numeric_text_classifier_top ntc_checker u_ntc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (char_i.ready),
  .out_valid_i    (class_o.valid),
  .out_ready_i    (class_o.ready),
  .number_class_i (class_o.number_class),
  .int_value_i    (class_o.int_value),
  .saturated_i    (class_o.saturated)
);

/* verif/numeric_text_classifier_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_text_classifier_top_tb
// streams short texts one character per item into the classifier and compares
// each class, integer value and saturation flag with a scan-state predictor;
// a directed table comes first, then random well-formed, mutated and noise
// texts with random idling on both channels
// ----------------------------------------------------------------------------
module numeric_text_classifier_top_tb;

  typedef struct packed {
    logic [ntc_pkg::ClassW-1:0] number_class;
    logic [ntc_pkg::ValueW-1:0] int_value;
    logic                       saturated;
  } class_res_t;

  typedef struct {
    bit         use_it;
    class_res_t res;
  } typed_t;

  typedef logic [ntc_pkg::CharW-1:0] text_t[$];

  localparam int NumDirected = 21;
  localparam int RandomChars = 820;

  logic clk_i = 1'b0;
  logic rst_ni;

  ntc_char_if  char_if ();
  ntc_class_if class_if ();

  numeric_text_classifier_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .class_o(class_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scan state of the predictor
  logic [ntc_pkg::PhaseW-1:0] sc_phase;
  logic                       sc_digit;
  logic                       sc_dot_exp;
  logic                       sc_neg;
  logic [ntc_pkg::ValueW-1:0] sc_mag;
  logic                       sc_ovf;

  class_res_t pending_classes[$];
  typed_t     typed_q[$];
  bit         tx_quiet;
  int         n_errors;

  // @ stands for a zero byte
  string dir_text [NumDirected] = '{
    "7", " -0 ", "+12", "1.5", ".5e-3", "-.E1", "1e", "2E+ ", "   ", "1 2", "@",
    "\377", "-9223372036854775808", "9223372036854775808",
    "-99999999999999999999", "3. ", ".", "-", "12e+7 ", "1e5x",
    "9223372036854775807"
  };
  bit dir_fixed [NumDirected] = '{
    1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1
  };
  class_res_t dir_res [NumDirected] = '{
    '{ntc_pkg::CLS_INT, 64'd7, 1'b0},          '{ntc_pkg::CLS_INT, 64'd0, 1'b0},
    '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},          '{ntc_pkg::CLS_REAL, 64'd0, 1'b0},
    '{ntc_pkg::CLS_REAL, 64'd0, 1'b0},         '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},
    '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},          '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},
    '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},          '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},
    '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},          '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},
    '{ntc_pkg::CLS_INT, ntc_pkg::LimitMag, 1'b0},
    '{ntc_pkg::CLS_INT, ntc_pkg::MaxPos, 1'b1},
    '{ntc_pkg::CLS_INT, ntc_pkg::LimitMag, 1'b1},
    '{ntc_pkg::CLS_REAL, 64'd0, 1'b0},
    '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},          '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},
    '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},          '{ntc_pkg::CLS_NAN, 64'd0, 1'b0},
    '{ntc_pkg::CLS_INT, ntc_pkg::MaxPos, 1'b0}
  };

  function automatic void clear_scan();
    sc_phase   = ntc_pkg::PH_LEAD;
    sc_digit   = 1'b0;
    sc_dot_exp = 1'b0;
    sc_neg     = 1'b0;
    sc_mag     = '0;
    sc_ovf     = 1'b0;
  endfunction

  function automatic void add_digit(input logic [ntc_pkg::CharW-1:0] c);
    logic [ntc_pkg::ValueW-1:0] d;
    d = ntc_pkg::ValueW'(c - ntc_pkg::CH_ZERO);
    if (!sc_ovf) begin
      if (sc_mag > (ntc_pkg::LimitMag - d) / 10) begin
        sc_ovf = 1'b1;
        sc_mag = ntc_pkg::LimitMag;
      end else begin
        sc_mag = sc_mag * 10 + d;
      end
    end
  endfunction

  function automatic void scan_char(input logic [ntc_pkg::CharW-1:0] c);
    logic is_dig, is_sgn, is_exp, is_sp;
    is_dig = (c >= ntc_pkg::CH_ZERO) && (c <= ntc_pkg::CH_NINE);
    is_sgn = (c == ntc_pkg::CH_PLUS) || (c == ntc_pkg::CH_MINUS);
    is_exp = (c == ntc_pkg::CH_LO_E) || (c == ntc_pkg::CH_UP_E);
    is_sp  = (c == ntc_pkg::CH_SPACE);
    case (sc_phase)
      ntc_pkg::PH_LEAD: begin
        if (is_sp) begin
          sc_phase = ntc_pkg::PH_LEAD;
        end else if (is_sgn) begin
          sc_neg   = (c == ntc_pkg::CH_MINUS);
          sc_phase = ntc_pkg::PH_INT;
        end else if (is_dig) begin
          sc_digit = 1'b1;
          add_digit(c);
          sc_phase = ntc_pkg::PH_INT;
        end else if (c == ntc_pkg::CH_DOT) begin
          sc_dot_exp = 1'b1;
          sc_phase   = ntc_pkg::PH_FRAC;
        end else begin
          sc_phase = ntc_pkg::PH_ERR;
        end
      end
      ntc_pkg::PH_INT: begin
        if (is_dig) begin
          sc_digit = 1'b1;
          add_digit(c);
        end else if (c == ntc_pkg::CH_DOT) begin
          sc_dot_exp = 1'b1;
          sc_phase   = ntc_pkg::PH_FRAC;
        end else if (is_exp) begin
          sc_dot_exp = 1'b1;
          sc_phase   = sc_digit ? ntc_pkg::PH_EXP0 : ntc_pkg::PH_ERR;
        end else if (is_sp) begin
          sc_phase = sc_digit ? ntc_pkg::PH_TRAIL : ntc_pkg::PH_ERR;
        end else begin
          sc_phase = ntc_pkg::PH_ERR;
        end
      end
      ntc_pkg::PH_FRAC: begin
        if (is_dig) sc_digit = 1'b1;
        else if (is_exp || is_sp) begin
          sc_phase = !sc_digit ? ntc_pkg::PH_ERR
                               : (is_exp ? ntc_pkg::PH_EXP0 : ntc_pkg::PH_TRAIL);
        end else sc_phase = ntc_pkg::PH_ERR;
      end
      ntc_pkg::PH_EXP0:
        sc_phase = is_sgn ? ntc_pkg::PH_EXPS : (is_dig ? ntc_pkg::PH_EXPD : ntc_pkg::PH_ERR);
      ntc_pkg::PH_EXPS: sc_phase = is_dig ? ntc_pkg::PH_EXPD : ntc_pkg::PH_ERR;
      ntc_pkg::PH_EXPD:
        sc_phase = is_dig ? ntc_pkg::PH_EXPD : (is_sp ? ntc_pkg::PH_TRAIL : ntc_pkg::PH_ERR);
      ntc_pkg::PH_TRAIL: sc_phase = is_sp ? ntc_pkg::PH_TRAIL : ntc_pkg::PH_ERR;
      default: sc_phase = ntc_pkg::PH_ERR;
    endcase
  endfunction

  function automatic class_res_t close_text();
    class_res_t r;
    r = '0;
    case (sc_phase)
      ntc_pkg::PH_INT:   r.number_class = sc_digit ? ntc_pkg::CLS_INT : ntc_pkg::CLS_NAN;
      ntc_pkg::PH_FRAC:  r.number_class = sc_digit ? ntc_pkg::CLS_REAL : ntc_pkg::CLS_NAN;
      ntc_pkg::PH_EXPD:  r.number_class = ntc_pkg::CLS_REAL;
      ntc_pkg::PH_TRAIL: r.number_class = sc_dot_exp ? ntc_pkg::CLS_REAL : ntc_pkg::CLS_INT;
      default:           r.number_class = ntc_pkg::CLS_NAN;
    endcase
    if (r.number_class == ntc_pkg::CLS_INT) begin
      if (sc_neg) begin
        r.saturated = sc_ovf;
        r.int_value = sc_ovf ? ntc_pkg::LimitMag : -sc_mag;
      end else if (sc_ovf || sc_mag > ntc_pkg::MaxPos) begin
        r.saturated = 1'b1;
        r.int_value = ntc_pkg::MaxPos;
      end else begin
        r.int_value = sc_mag;
      end
    end
    clear_scan();
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    class_res_t exp_res;
    class_res_t got_res;
    typed_t     tq;
    if (rst_ni && char_if.valid && char_if.ready) begin
      scan_char(char_if.char_code);
      if (char_if.final_char) begin
        exp_res = close_text();
        if (typed_q.size() != 0) begin
          tq = typed_q.pop_front();
          if (tq.use_it) exp_res = tq.res;
        end
        pending_classes.push_back(exp_res);
      end
    end
    if (rst_ni && class_if.valid && class_if.ready) begin
      got_res = '{class_if.number_class, class_if.int_value, class_if.saturated};
      if (pending_classes.size() == 0) begin
        $error("result with no text pending: class %0d", got_res.number_class);
        n_errors++;
      end else begin
        exp_res = pending_classes.pop_front();
        if (got_res.number_class !== exp_res.number_class) begin
          $error("number_class: expected %0d, got %0d",
                 exp_res.number_class, got_res.number_class);
          n_errors++;
        end
        if (got_res.int_value !== exp_res.int_value) begin
          $error("int_value: expected %0d, got %0d",
                 $signed(exp_res.int_value), $signed(got_res.int_value));
          n_errors++;
        end
        if (got_res.saturated !== exp_res.saturated) begin
          $error("saturated: expected %0d, got %0d",
                 exp_res.saturated, got_res.saturated);
          n_errors++;
        end
      end
    end
  end

  task automatic send_char(input logic [ntc_pkg::CharW-1:0] code, input bit last);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_if.valid      <= 1'b1;
    char_if.char_code  <= code;
    char_if.final_char <= last;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
  endtask

  task automatic send_text(input text_t txt);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    char_if.valid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk_i);
  endtask

  function automatic text_t make_text();
    text_t t;
    string near_max;
    int unsigned ndig;
    near_max = "92233720368547758";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) t.push_back(ntc_pkg::CharW'($urandom_range(0, 255)));
      return t;
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) t.push_back(ntc_pkg::CH_SPACE);
    if ($urandom_range(0, 2) == 0)
      t.push_back($urandom_range(0, 1) ? ntc_pkg::CH_MINUS : ntc_pkg::CH_PLUS);
    if ($urandom_range(0, 6) == 0) begin
      for (int i = 0; i < near_max.len(); i++) t.push_back(near_max[i]);
      ndig = $urandom_range(1, 3);
    end else if ($urandom_range(0, 9) == 0) begin
      ndig = $urandom_range(17, 21);
    end else begin
      ndig = $urandom_range(0, 6);
    end
    repeat (ndig) t.push_back(ntc_pkg::CH_ZERO + ntc_pkg::CharW'($urandom_range(0, 9)));
    if ($urandom_range(0, 3) == 0) begin
      t.push_back(ntc_pkg::CH_DOT);
      repeat ($urandom_range(0, 3))
        t.push_back(ntc_pkg::CH_ZERO + ntc_pkg::CharW'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 4) == 0) begin
      t.push_back($urandom_range(0, 1) ? ntc_pkg::CH_LO_E : ntc_pkg::CH_UP_E);
      if ($urandom_range(0, 1))
        t.push_back($urandom_range(0, 1) ? ntc_pkg::CH_MINUS : ntc_pkg::CH_PLUS);
      repeat ($urandom_range(0, 2))
        t.push_back(ntc_pkg::CH_ZERO + ntc_pkg::CharW'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) t.push_back(ntc_pkg::CH_SPACE);
    if (t.size() == 0) t.push_back(ntc_pkg::CH_ZERO + ntc_pkg::CharW'($urandom_range(0, 9)));
    // broken texts
    if ($urandom_range(0, 4) == 0) begin
      ndig = $urandom_range(0, t.size() - 1);
      case ($urandom_range(0, 2))
        0: t[ndig] = ntc_pkg::CharW'($urandom_range(0, 255));
        1: t.insert(ndig, ntc_pkg::CH_SPACE);
        default: if (t.size() > 1) t.delete(ndig);
      endcase
    end
    return t;
  endfunction

  initial begin
    rst_ni             = 1'b0;
    char_if.valid      = 1'b0;
    char_if.char_code  = '0;
    char_if.final_char = 1'b0;
    class_if.ready     = 1'b0;
    tx_quiet           = 1'b0;
    n_errors           = 0;
    clear_scan();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin : text_source
    text_t txt;
    int unsigned sent;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    wait (rst_ni === 1'b1);
    for (int r = 0; r < NumDirected; r++) begin
      txt.delete();
      for (int i = 0; i < dir_text[r].len(); i++)
        txt.push_back(dir_text[r][i] == "@" ? 8'h00 : dir_text[r][i]);
      typed_q.push_back('{dir_fixed[r], dir_res[r]});
      tx_quiet = ($urandom_range(0, 3) == 0);
      send_text(txt);
    end
    drain_results();
    while (sent < RandomChars) begin
      if (!paused && sent >= RandomChars / 2) begin
        paused = 1'b1;
        drain_results();
      end
      txt      = make_text();
      tx_quiet = ($urandom_range(0, 5) == 0);
      typed_q.push_back('{1'b0, '0});
      send_text(txt);
      sent += txt.size();
    end
    @(negedge clk_i);
    char_if.valid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned taken;
    int unsigned gap;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 17);
      // long hold-off so the block backs up into the character channel
      if (taken == 40) gap = 300;
      @(negedge clk_i);
      if (gap != 0) begin
        class_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      class_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!class_if.valid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
